// ----- rtl/fpm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fpm_pkg: shared types and constants of the frame PSNR meter
// Holds the channel payload structs, the commands of the shared arithmetic
// unit and the fixed-point constants of the log conversion.
// ----------------------------------------------------------------------------
package fpm_pkg;

   // Accumulator and output formats
   localparam int COUNT_BITS    = 26;
   localparam int FRACTION_BITS = 8;
   localparam int PSNR_BITS     = 18;
   localparam int SUM_BITS      = 64;
   localparam int SQ_BITS       = 32;

   // log2 in Q.LOG_FRAC, integer part 0..63
   localparam int LOG_FRAC      = 24;
   localparam int EXP_BITS      = 6;
   localparam int LG_BITS       = 32;
   localparam int NORM_STEPS    = 6;

   // 10*log10(2) in Q.24, rounding and scaling of the final product
   localparam logic [31:0] TEN_LOG10_2 = 32'd50504453;
   localparam int          SCALE_SHIFT = 48 - FRACTION_BITS;
   localparam logic [63:0] PSNR_CAP    = 64'(1000) << FRACTION_BITS;

   // Configuration
   localparam logic [4:0] BIT_DEPTH_RESET = 5'd8;
   localparam logic [4:0] BIT_DEPTH_MIN   = 5'd1;
   localparam logic [4:0] BIT_DEPTH_MAX   = 5'd16;

   // Plane codes
   localparam logic [1:0] PLANE_Y = 2'd0;
   localparam logic [1:0] PLANE_U = 2'd1;
   localparam logic [1:0] PLANE_V = 2'd2;

   // Arithmetic unit operations
   localparam logic OP_LOG   = 1'b0;
   localparam logic OP_SCALE = 1'b1;

   typedef struct packed {
      logic [15:0] pixel_ref;
      logic [15:0] pixel_test;
      logic [1:0]  plane;
      logic        frame_end;
   } fpm_req_type;

   typedef struct packed {
      logic [PSNR_BITS-1:0] psnr_y;
      logic [PSNR_BITS-1:0] psnr_u;
      logic [PSNR_BITS-1:0] psnr_v;
      logic                 sum_saturated;
   } fpm_rsp_type;

   typedef struct packed {
      logic                start;
      logic                op;
      logic [SUM_BITS-1:0] operand;
   } fpm_cmd_type;

   typedef struct packed {
      logic               done;
      logic [LG_BITS-1:0] value;
   } fpm_res_type;

   typedef struct packed {
      logic take;
      logic clear;
   } fpm_acc_ctrl_type;

   typedef struct packed {
      logic busy;
      logic sat;
   } fpm_acc_sts_type;

endpackage
`default_nettype wire

// ----- rtl/fpm_accum.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fpm_accum: per-plane squared error and sample count accumulator
// Stage one squares the sample difference, stage two adds it to the plane's
// saturating 64-bit sum and bumps the saturating sample count.
// ----------------------------------------------------------------------------
module fpm_accum (
   input  wire                               clock,
   input  wire                               reset,
   input  fpm_pkg::fpm_acc_ctrl_type         ctrl,
   input  fpm_pkg::fpm_req_type              req,
   output logic [fpm_pkg::SUM_BITS-1:0]      sum_out   [0:2],
   output logic [fpm_pkg::COUNT_BITS-1:0]    count_out [0:2],
   output fpm_pkg::fpm_acc_sts_type          sts
);

   logic                              s1_valid_ff, s1_valid_in;
   logic [1:0]                        s1_plane_ff, s1_plane_in;
   logic [fpm_pkg::SQ_BITS-1:0]       s1_sq_ff, s1_sq_in;
   logic [fpm_pkg::SUM_BITS-1:0]      sum_ff   [0:2];
   logic [fpm_pkg::SUM_BITS-1:0]      sum_in   [0:2];
   logic [fpm_pkg::COUNT_BITS-1:0]    count_ff [0:2];
   logic [fpm_pkg::COUNT_BITS-1:0]    count_in [0:2];
   logic                              sat_ff, sat_in;
   logic [15:0]                       diff;
   logic [fpm_pkg::SUM_BITS:0]        sum_add  [0:2];

   // Square the absolute difference; drop the unused plane code
   always_comb begin
      diff = (req.pixel_ref >= req.pixel_test) ? (req.pixel_ref - req.pixel_test)
                                               : (req.pixel_test - req.pixel_ref);
      s1_sq_in    = diff * diff;
      s1_plane_in = req.plane;
      s1_valid_in = ctrl.take && (req.plane <= fpm_pkg::PLANE_V);
   end

   // Add the square into the addressed plane, saturating sum and count
   always_comb begin
      sat_in = sat_ff;
      for (int i = 0; i < 3; i++) begin
         sum_add[i]  = {1'b0, sum_ff[i]} + (fpm_pkg::SUM_BITS+1)'(s1_sq_ff);
         sum_in[i]   = sum_ff[i];
         count_in[i] = count_ff[i];
         if (s1_valid_ff && (s1_plane_ff == 2'(i))) begin
            if (sum_add[i][fpm_pkg::SUM_BITS]) begin
               sum_in[i] = '1;
               sat_in    = 1'b1;
            end else begin
               sum_in[i] = sum_add[i][fpm_pkg::SUM_BITS-1:0];
            end
            if (count_ff[i] != '1) begin
               count_in[i] = count_ff[i] + 1'b1;
            end
         end
      end
      if (ctrl.clear) begin
         for (int i = 0; i < 3; i++) begin
            sum_in[i]   = '0;
            count_in[i] = '0;
         end
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      s1_plane_ff <= s1_plane_in;
      s1_sq_ff    <= s1_sq_in;
      if (reset) begin
         s1_valid_ff <= 1'b0;
         sat_ff      <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i]   <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff <= s1_valid_in;
         sat_ff      <= sat_in;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i]   <= sum_in[i];
            count_ff[i] <= count_in[i];
         end
      end
   end

   assign sum_out   = sum_ff;
   assign count_out = count_ff;
   assign sts.busy  = s1_valid_ff;
   assign sts.sat   = sat_ff;

   // Flag rises only together with a sum pinned at full scale
   a_sat_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(sat_ff) |-> (sum_ff[0] == '1 || sum_ff[1] == '1 || sum_ff[2] == '1))
      else $error("saturation flag set without a saturated sum");

endmodule
`default_nettype wire

// ----- rtl/fpm_arith_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fpm_arith_unit: shared log2 and dB scaling unit
// A log takes a binary-search normalise (one halving step a cycle) and then
// one squaring of the mantissa per fraction bit. Scaling reuses the same
// 32x32 multiplier, then rounds, shifts and caps the product.
// ----------------------------------------------------------------------------
module fpm_arith_unit (
   input  wire                       clock,
   input  wire                       reset,
   input  fpm_pkg::fpm_cmd_type      cmd,
   output fpm_pkg::fpm_res_type      res
);

   localparam logic [2:0] U_IDLE = 3'd0;
   localparam logic [2:0] U_NORM = 3'd1;
   localparam logic [2:0] U_FRAC = 3'd2;
   localparam logic [2:0] U_MUL  = 3'd3;
   localparam logic [2:0] U_RND  = 3'd4;

   logic [2:0]                       u_state_ff, u_state_in;
   logic [fpm_pkg::SUM_BITS-1:0]     x_ff, x_in;
   logic [fpm_pkg::EXP_BITS-1:0]     exp_ff, exp_in;
   logic [2:0]                       step_ff, step_in;
   logic [31:0]                      m_ff, m_in;
   logic [4:0]                       bit_ff, bit_in;
   logic [fpm_pkg::LG_BITS-1:0]      acc_ff, acc_in;
   logic                             done_ff, done_in;

   logic                             zero_top;
   logic [fpm_pkg::EXP_BITS-1:0]     amt;
   logic [fpm_pkg::SUM_BITS-1:0]     x_norm;
   logic [fpm_pkg::EXP_BITS-1:0]     exp_norm;
   logic [31:0]                      mul_a, mul_b;
   logic [63:0]                      product;
   logic [32:0]                      sq_top;
   logic [31:0]                      m_next;
   logic [63:0]                      rnd;
   logic [63:0]                      scaled;
   logic [63:0]                      capped;

   // One halving step of the leading-one search
   always_comb begin
      case (step_ff)
         3'd0: begin zero_top = (x_ff[63:32] == '0); amt = 6'd32; end
         3'd1: begin zero_top = (x_ff[63:48] == '0); amt = 6'd16; end
         3'd2: begin zero_top = (x_ff[63:56] == '0); amt = 6'd8;  end
         3'd3: begin zero_top = (x_ff[63:60] == '0); amt = 6'd4;  end
         3'd4: begin zero_top = (x_ff[63:62] == '0); amt = 6'd2;  end
         3'd5: begin zero_top = !x_ff[63];          amt = 6'd1;  end
         default: begin zero_top = 1'b0; amt = '0; end
      endcase
      x_norm   = zero_top ? (x_ff << amt) : x_ff;
      exp_norm = zero_top ? (exp_ff - amt) : exp_ff;
   end

   // Shared multiplier: mantissa square or dB scaling
   always_comb begin
      mul_a   = (u_state_ff == U_FRAC) ? m_ff : x_ff[31:0];
      mul_b   = (u_state_ff == U_FRAC) ? m_ff : fpm_pkg::TEN_LOG10_2;
      product = mul_a * mul_b;
      sq_top  = product[63:31];
      m_next  = sq_top[32] ? sq_top[32:1] : sq_top[31:0];
   end

   // Round, shift and cap the scaled log
   always_comb begin
      rnd    = x_ff + (64'd1 << (fpm_pkg::SCALE_SHIFT - 1));
      scaled = rnd >> fpm_pkg::SCALE_SHIFT;
      capped = (scaled > fpm_pkg::PSNR_CAP) ? fpm_pkg::PSNR_CAP : scaled;
   end

   // Sequence the unit
   always_comb begin
      u_state_in = u_state_ff;
      x_in       = x_ff;
      exp_in     = exp_ff;
      step_in    = step_ff;
      m_in       = m_ff;
      bit_in     = bit_ff;
      acc_in     = acc_ff;
      done_in    = 1'b0;
      case (u_state_ff)
         U_IDLE: begin
            if (cmd.start) begin
               x_in    = cmd.operand;
               exp_in  = '1;
               step_in = '0;
               u_state_in = (cmd.op == fpm_pkg::OP_LOG) ? U_NORM : U_MUL;
            end
         end
         U_NORM: begin
            x_in    = x_norm;
            exp_in  = exp_norm;
            step_in = step_ff + 3'd1;
            if (step_ff == 3'(fpm_pkg::NORM_STEPS - 1)) begin
               m_in   = x_norm[63:32];
               acc_in = {{(fpm_pkg::LG_BITS - fpm_pkg::EXP_BITS - fpm_pkg::LOG_FRAC){1'b0}},
                         exp_norm, {fpm_pkg::LOG_FRAC{1'b0}}};
               bit_in = 5'(fpm_pkg::LOG_FRAC - 1);
               u_state_in = U_FRAC;
            end
         end
         U_FRAC: begin
            m_in = m_next;
            if (sq_top[32]) begin
               acc_in = acc_ff | (32'd1 << bit_ff);
            end
            bit_in = bit_ff - 5'd1;
            if (bit_ff == '0) begin
               done_in    = 1'b1;
               u_state_in = U_IDLE;
            end
         end
         U_MUL: begin
            x_in       = product;
            u_state_in = U_RND;
         end
         U_RND: begin
            acc_in     = 32'(capped[fpm_pkg::PSNR_BITS-1:0]);
            done_in    = 1'b1;
            u_state_in = U_IDLE;
         end
         default: begin
            u_state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      exp_ff  <= exp_in;
      m_ff    <= m_in;
      bit_ff  <= bit_in;
      acc_ff  <= acc_in;
      if (reset) begin
         u_state_ff <= U_IDLE;
         step_ff    <= '0;
         done_ff    <= 1'b0;
      end else begin
         u_state_ff <= u_state_in;
         step_ff    <= step_in;
         done_ff    <= done_in;
      end
   end

   assign res.done  = done_ff;
   assign res.value = acc_ff;

   // Commands arrive only while the unit is free
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> (u_state_ff == U_IDLE))
      else $error("arithmetic unit started while busy");

endmodule
`default_nettype wire

// ----- rtl/frame_psnr_meter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// frame_psnr_meter: per-plane PSNR of a test frame against a reference frame
// Sample pairs arrive on the req_ channel (valid/stall), tagged Y, U or V;
// a plane code of three is ignored. Pairs are taken one per cycle while
// req_stall is low and go through a two-stage square-and-accumulate pipe.
// The pair flagged frame_end is accumulated, then req_stall rises while the
// sequencer works out the three PSNR values on one shared log/multiply unit:
// seven log2 conversions (6 normalise steps plus 24 mantissa squarings each)
// and three short scaling passes, with less work when a plane has zero error.
// The result sits in an output register on the rsp_ channel; a stalled
// result holds and the block goes on taking pairs, and only the next frame
// end waits for it to go. The csr_ port writes the bit depth (always ready);
// the user must use it only while the block is idle; the block won't check.
// Reset clears the sums, counts, saturation flag and all valids, and sets
// the bit depth to 8.
// ----------------------------------------------------------------------------
module frame_psnr_meter (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  fpm_pkg::fpm_req_type  req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output fpm_pkg::fpm_rsp_type  rsp_data,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire  [4:0]            csr_wdata
);

   localparam logic [3:0] S_RUN        = 4'd0;
   localparam logic [3:0] S_DRAIN      = 4'd1;
   localparam logic [3:0] S_DYN_GO     = 4'd2;
   localparam logic [3:0] S_DYN_WAIT   = 4'd3;
   localparam logic [3:0] S_PLANE      = 4'd4;
   localparam logic [3:0] S_CNT_GO     = 4'd5;
   localparam logic [3:0] S_CNT_WAIT   = 4'd6;
   localparam logic [3:0] S_SUM_GO     = 4'd7;
   localparam logic [3:0] S_SUM_WAIT   = 4'd8;
   localparam logic [3:0] S_SCALE_GO   = 4'd9;
   localparam logic [3:0] S_SCALE_WAIT = 4'd10;
   localparam logic [3:0] S_NEXT       = 4'd11;
   localparam logic [3:0] S_OUT        = 4'd12;

   logic [3:0]                         state_ff, state_in;
   logic [1:0]                         p_ff, p_in;
   logic [4:0]                         bit_depth_ff, bit_depth_in;
   logic [fpm_pkg::LG_BITS-1:0]        lgd_ff, lgd_in;
   logic signed [fpm_pkg::LG_BITS-1:0] lacc_ff, lacc_in;
   logic [fpm_pkg::PSNR_BITS-1:0]      psnr_ff [0:2];
   logic [fpm_pkg::PSNR_BITS-1:0]      psnr_in [0:2];
   logic                               rsp_valid_ff, rsp_valid_in;
   fpm_pkg::fpm_rsp_type               rsp_data_ff, rsp_data_in;

   fpm_pkg::fpm_acc_ctrl_type          acc_ctrl;
   fpm_pkg::fpm_acc_sts_type           acc_sts;
   fpm_pkg::fpm_cmd_type               cmd;
   fpm_pkg::fpm_res_type               res;
   logic [fpm_pkg::SUM_BITS-1:0]       sums   [0:2];
   logic [fpm_pkg::COUNT_BITS-1:0]     counts [0:2];

   logic                               take;
   logic                               rsp_free;
   logic [4:0]                         bd;
   logic [5:0]                         bd_x2;
   logic [5:0]                         bd_p1;
   logic [fpm_pkg::SUM_BITS-1:0]       dyn2;
   logic [fpm_pkg::SUM_BITS-1:0]       sum_sel;
   logic [fpm_pkg::COUNT_BITS-1:0]     count_sel;
   logic signed [fpm_pkg::LG_BITS-1:0] l_next;

   fpm_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (acc_ctrl),
      .req       (req_data),
      .sum_out   (sums),
      .count_out (counts),
      .sts       (acc_sts)
   );

   fpm_arith_unit u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .res   (res)
   );

   // Handshakes
   assign req_stall = (state_ff != S_RUN);
   assign take      = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // Clamp bit depth and form the squared peak value
   always_comb begin
      if (bit_depth_ff < fpm_pkg::BIT_DEPTH_MIN) begin
         bd = fpm_pkg::BIT_DEPTH_MIN;
      end else if (bit_depth_ff > fpm_pkg::BIT_DEPTH_MAX) begin
         bd = fpm_pkg::BIT_DEPTH_MAX;
      end else begin
         bd = bit_depth_ff;
      end
      bd_x2 = {bd, 1'b0};
      bd_p1 = 6'(bd) + 6'd1;
      dyn2  = (64'd1 << bd_x2) - (64'd1 << bd_p1) + 64'd1;
   end

   assign sum_sel   = sums[p_ff];
   assign count_sel = counts[p_ff];
   assign l_next    = lacc_ff - $signed(res.value);

   // Drive the arithmetic unit from the go states
   always_comb begin
      cmd.start   = (state_ff == S_DYN_GO) || (state_ff == S_CNT_GO) ||
                    (state_ff == S_SUM_GO) || (state_ff == S_SCALE_GO);
      cmd.op      = (state_ff == S_SCALE_GO) ? fpm_pkg::OP_SCALE : fpm_pkg::OP_LOG;
      case (state_ff)
         S_DYN_GO:   cmd.operand = dyn2;
         S_CNT_GO:   cmd.operand = fpm_pkg::SUM_BITS'(count_sel);
         S_SUM_GO:   cmd.operand = sum_sel;
         S_SCALE_GO: cmd.operand = fpm_pkg::SUM_BITS'(unsigned'(lacc_ff));
         default:    cmd.operand = '0;
      endcase
   end

   // Frame-end sequencer
   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      lgd_in       = lgd_ff;
      lacc_in      = lacc_ff;
      psnr_in      = psnr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      acc_ctrl.take  = take;
      acc_ctrl.clear = 1'b0;
      bit_depth_in = (csr_valid && csr_ready) ? csr_wdata : bit_depth_ff;
      case (state_ff)
         S_RUN: begin
            if (take && req_data.frame_end) begin
               p_in     = fpm_pkg::PLANE_Y;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!acc_sts.busy) begin
               state_in = S_DYN_GO;
            end
         end
         S_DYN_GO:  state_in = S_DYN_WAIT;
         S_DYN_WAIT: begin
            if (res.done) begin
               lgd_in   = res.value;
               state_in = S_PLANE;
            end
         end
         S_PLANE: begin
            if (sum_sel == '0) begin
               psnr_in[p_ff] = fpm_pkg::PSNR_CAP[fpm_pkg::PSNR_BITS-1:0];
               state_in      = S_NEXT;
            end else if (count_sel == '0) begin
               psnr_in[p_ff] = '0;
               state_in      = S_NEXT;
            end else begin
               state_in = S_CNT_GO;
            end
         end
         S_CNT_GO:  state_in = S_CNT_WAIT;
         S_CNT_WAIT: begin
            if (res.done) begin
               lacc_in  = $signed(lgd_ff + res.value);
               state_in = S_SUM_GO;
            end
         end
         S_SUM_GO:  state_in = S_SUM_WAIT;
         S_SUM_WAIT: begin
            if (res.done) begin
               lacc_in = l_next;
               if (l_next <= 0) begin
                  psnr_in[p_ff] = '0;
                  state_in      = S_NEXT;
               end else begin
                  state_in = S_SCALE_GO;
               end
            end
         end
         S_SCALE_GO: state_in = S_SCALE_WAIT;
         S_SCALE_WAIT: begin
            if (res.done) begin
               psnr_in[p_ff] = res.value[fpm_pkg::PSNR_BITS-1:0];
               state_in      = S_NEXT;
            end
         end
         S_NEXT: begin
            if (p_ff == fpm_pkg::PLANE_V) begin
               state_in = S_OUT;
            end else begin
               p_in     = p_ff + 2'd1;
               state_in = S_PLANE;
            end
         end
         S_OUT: begin
            // Load the result once the output register is free, then clear
            if (rsp_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.psnr_y         = psnr_ff[0];
               rsp_data_in.psnr_u         = psnr_ff[1];
               rsp_data_in.psnr_v         = psnr_ff[2];
               rsp_data_in.sum_saturated  = acc_sts.sat;
               acc_ctrl.clear             = 1'b1;
               state_in                   = S_RUN;
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      p_ff        <= p_in;
      lgd_ff      <= lgd_in;
      lacc_ff     <= lacc_in;
      psnr_ff     <= psnr_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_RUN;
         rsp_valid_ff <= 1'b0;
         bit_depth_ff <= fpm_pkg::BIT_DEPTH_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bit_depth_ff <= bit_depth_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Accumulate pipe is only busy before the sequencer starts
   a_busy_in_run: assert property (@(posedge clock) disable iff (reset)
      acc_sts.busy |-> (state_ff == S_RUN || state_ff == S_DRAIN))
      else $error("accumulator busy during frame-end sequence");

   // Unit results land only in a wait state
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      res.done |-> (state_ff == S_DYN_WAIT || state_ff == S_CNT_WAIT ||
                    state_ff == S_SUM_WAIT || state_ff == S_SCALE_WAIT))
      else $error("arithmetic result arrived outside a wait state");

   // Clearing never races an accumulation
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      acc_ctrl.clear |-> !acc_sts.busy)
      else $error("accumulator cleared with a transfer in flight");

   // A loaded result is presented on the next cycle
   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_free) |=> (rsp_valid_ff && state_ff == S_RUN))
      else $error("result not loaded");

endmodule
`default_nettype wire
